### design/wsmhd_pkg.sv
// wsmhd_pkg: shared widths, codes, command/status types and cosine table function
`timescale 1ns / 1ps

package wsmhd_pkg;

  // field widths
  localparam int ACTION_W   = 2;
  localparam int LIN_W      = 11;
  localparam int HEAD_W     = 10;
  localparam int TURN_W     = 11;
  localparam int DSPD_W     = 11;
  localparam int DUTY_W     = 8;
  localparam int SPEED_W    = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 9;

  // parameter defaults
  localparam int unsigned DUTY_MAX_DEF  = 255;
  localparam int unsigned COS_FRAC_DEF  = 15;

  // cosine table geometry
  localparam int COS_ENTRIES = 91;
  localparam int COS_IDX_W   = 7;
  localparam int COS_DEPTH   = 1 << COS_IDX_W;

  // angle reduction: offset keeps theta positive, reciprocal for /360
  localparam int DEG_FULL   = 360;
  localparam int DEG_HALF   = 180;
  localparam int DEG_3Q     = 270;
  localparam int DEG_Q      = 90;
  localparam int THETA_W    = 14;
  localparam int THETA_OFS  = 12 * DEG_FULL;
  localparam int DIV_MUL    = 2913;
  localparam int DIV_MUL_W  = 12;
  localparam int DIV_SHIFT  = 20;
  localparam int QUO_W      = 5;
  localparam int DEG_W      = 9;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SET        = 2'd0,
    ACT_RUN_STORED = 2'd1,
    ACT_RUN_DIRECT = 2'd2,
    ACT_BRAKE      = 2'd3
  } action_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LOCATION     = 3'd0,
    REG_DIRECTION    = 3'd1,
    REG_ANGLE_COEF   = 3'd2,
    REG_ANGULAR_COEF = 3'd3,
    REG_COS_GAIN     = 3'd4,
    REG_MIN_SPEED    = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_THETA,
    OP_DIV,
    OP_FOLD,
    OP_QUAD,
    OP_ROM,
    OP_MUL,
    OP_SUM,
    OP_RND,
    OP_FIN,
    OP_DRIVE
  } dp_op_t;

  typedef struct packed {
    logic   load_in;
    logic   load_out;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_set;
  } dp_status_t;

  // cos of q degrees (q in 0..90) in Q30, ten-term series, clamped
  function automatic logic [30:0] cos_q30(input int q);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x    = (64'(q) * PI_Q30) / 180;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = longint'(term);
    term = ((term * x2) >> 30) / 2;   sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 12;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 30;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 56;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 90;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 132; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 182; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 240; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 306; sum = sum - longint'(term);
    if (sum < 0) sum = 0;
    if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
    return 31'(sum);
  endfunction

endpackage

### design/wsmhd_if.sv
// wsmhd_if: valid/ready channel interfaces for commands, results and configuration
`timescale 1ns / 1ps

interface wsmhd_cmd_if import wsmhd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ACTION_W-1:0]      action;
  logic signed [LIN_W-1:0]  lin_speed;
  logic signed [HEAD_W-1:0] heading_angle;
  logic signed [TURN_W-1:0] turn_rate;
  logic signed [DSPD_W-1:0] direct_speed;

  modport source (output valid, action, lin_speed, heading_angle, turn_rate,
                  direct_speed, input ready);
  modport sink   (input valid, action, lin_speed, heading_angle, turn_rate,
                  direct_speed, output ready);
endinterface

interface wsmhd_res_if import wsmhd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [DUTY_W-1:0]         pin_a_duty;
  logic [DUTY_W-1:0]         pin_b_duty;
  logic                      pins_updated;
  logic signed [SPEED_W-1:0] wheel_speed;

  modport source (output valid, pin_a_duty, pin_b_duty, pins_updated, wheel_speed,
                  input ready);
  modport sink   (input valid, pin_a_duty, pin_b_duty, pins_updated, wheel_speed,
                  output ready);
endinterface

interface wsmhd_cfg_if import wsmhd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

### design/wheel_speed_mixer_hbridge_drive.sv
// wheel_speed_mixer_hbridge_drive: omni-wheel speed mixer and h-bridge pwm driver, top level
//
//  channel | dir | beat contents
//  --------+-----+-----------------------------------------------------------------
//  cmd     | in  | action, lin_speed, heading_angle, turn_rate, direct_speed
//  res     | out | pin_a_duty, pin_b_duty, pins_updated, wheel_speed
//  cfg     | in  | addr (register index 0..5), data (register value, low bits used)
//
//  a set-velocity beat occupies the block from acceptance to the next acceptance:
//  dispatch, eight one-step arithmetic stages of the shared datapath, done, idle
//  run and brake beats step through dispatch, done, idle
//  one command is in flight at a time; a finished result sits in the output register
//  while the next command is accepted and worked on
//  a stalled result only holds the sequencer in its done step; rst is synchronous
//  and returns the config registers to their defaults and clears speed and bridge state
`timescale 1ns / 1ps

module wheel_speed_mixer_hbridge_drive import wsmhd_pkg::*; #(
  parameter int unsigned DUTY_MAX      = DUTY_MAX_DEF,
  parameter int unsigned COS_FRAC_BITS = COS_FRAC_DEF
) (
  input logic        clk,
  input logic        rst,
  wsmhd_cmd_if.sink  cmd,
  wsmhd_res_if.source res,
  wsmhd_cfg_if.sink  cfg
);

  dp_cmd_t    ctl;
  dp_status_t status;

  // config writes are registered and always taken
  assign cfg.ready = 1'b1;

  // sequencer: owns handshakes and the output valid bit
  wsmhd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .status    (status),
    .ctl       (ctl)
  );

  // datapath: config, stored speed, bridge state, arithmetic and result payload
  wsmhd_dp #(
    .DUTY_MAX      (DUTY_MAX),
    .COS_FRAC_BITS (COS_FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .status        (status),
    .cfg_we        (cfg.valid),
    .cfg_addr      (cfg.addr),
    .cfg_data      (cfg.data),
    .action        (cmd.action),
    .lin_speed     (cmd.lin_speed),
    .heading_angle (cmd.heading_angle),
    .turn_rate     (cmd.turn_rate),
    .direct_speed  (cmd.direct_speed),
    .pin_a_duty    (res.pin_a_duty),
    .pin_b_duty    (res.pin_b_duty),
    .pins_updated  (res.pins_updated),
    .wheel_speed   (res.wheel_speed)
  );

endmodule

### design/wsmhd_ctrl.sv
// wsmhd_ctrl: sequencer that steps the datapath through one command
`timescale 1ns / 1ps

module wsmhd_ctrl import wsmhd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    ctl
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DIV,
    ST_FOLD,
    ST_QUAD,
    ST_ROM,
    ST_MUL,
    ST_SUM,
    ST_RND,
    ST_FIN,
    ST_DONE
  } state_t;

  state_t state;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);

  always_comb begin
    ctl.load_in  = in_valid && in_ready;
    ctl.load_out = (state == ST_DONE) && slot_free;
    case (state)
      ST_DISPATCH: ctl.op = status.is_set ? OP_THETA : OP_DRIVE;
      ST_DIV:      ctl.op = OP_DIV;
      ST_FOLD:     ctl.op = OP_FOLD;
      ST_QUAD:     ctl.op = OP_QUAD;
      ST_ROM:      ctl.op = OP_ROM;
      ST_MUL:      ctl.op = OP_MUL;
      ST_SUM:      ctl.op = OP_SUM;
      ST_RND:      ctl.op = OP_RND;
      ST_FIN:      ctl.op = OP_FIN;
      default:     ctl.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == ST_DONE) && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE:     if (in_valid) state <= ST_DISPATCH;
        ST_DISPATCH: state <= status.is_set ? ST_DIV : ST_DONE;
        ST_DIV:      state <= ST_FOLD;
        ST_FOLD:     state <= ST_QUAD;
        ST_QUAD:     state <= ST_ROM;
        ST_ROM:      state <= ST_MUL;
        ST_MUL:      state <= ST_SUM;
        ST_SUM:      state <= ST_RND;
        ST_RND:      state <= ST_FIN;
        ST_FIN:      state <= ST_DONE;
        ST_DONE:     if (slot_free) state <= ST_IDLE;
        default:     state <= ST_IDLE;
      endcase
    end
  end

endmodule

### design/wsmhd_dp.sv
// wsmhd_dp: config registers, speed mixing arithmetic, bridge drive and result register
`timescale 1ns / 1ps

module wsmhd_dp import wsmhd_pkg::*; #(
  parameter int unsigned DUTY_MAX      = DUTY_MAX_DEF,
  parameter int unsigned COS_FRAC_BITS = COS_FRAC_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  dp_cmd_t                   ctl,
  output dp_status_t                status,
  input  logic                      cfg_we,
  input  logic [CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic [ACTION_W-1:0]       action,
  input  logic signed [LIN_W-1:0]   lin_speed,
  input  logic signed [HEAD_W-1:0]  heading_angle,
  input  logic signed [TURN_W-1:0]  turn_rate,
  input  logic signed [DSPD_W-1:0]  direct_speed,
  output logic [DUTY_W-1:0]         pin_a_duty,
  output logic [DUTY_W-1:0]         pin_b_duty,
  output logic                      pins_updated,
  output logic signed [SPEED_W-1:0] wheel_speed
);

  localparam int F      = int'(COS_FRAC_BITS);
  localparam int COS_W  = F + 1;
  localparam int COS_SW = F + 2;
  localparam int PROD_W = 18;
  localparam int SUM_W  = F + 20;
  localparam int VMAG_W = SUM_W - F;
  localparam int VS_W   = VMAG_W + 1;
  localparam int MAG_W  = SPEED_W + 1;
  localparam logic [MAG_W-1:0] DUTY_CAP = MAG_W'(DUTY_MAX);

  // config registers
  logic [DEG_W-1:0]       loc;
  logic signed [1:0]      dir;
  logic signed [3:0]      acoef;
  logic signed [6:0]      wcoef;
  logic signed [6:0]      cgain;
  logic [DUTY_W-1:0]      mins;

  // architectural state
  logic signed [SPEED_W-1:0] stored_speed;
  logic [DUTY_W-1:0]         held_a;
  logic [DUTY_W-1:0]         held_b;

  // captured item
  action_t                  act;
  logic signed [LIN_W-1:0]  lin;
  logic signed [HEAD_W-1:0] head;
  logic signed [TURN_W-1:0] turn;
  logic signed [DSPD_W-1:0] dspd;

  // pipeline registers of the set sequence
  logic [THETA_W-1:0]       theta_ofs;
  logic [QUO_W-1:0]         quo;
  logic [DEG_W-1:0]         deg;
  logic [COS_IDX_W-1:0]     cos_idx;
  logic                     cos_neg;
  logic signed [COS_SW-1:0] cos_s;
  logic signed [PROD_W-1:0] p1;
  logic signed [PROD_W-1:0] tt;
  logic signed [SUM_W-1:0]  p2;
  logic signed [SUM_W-1:0]  total;
  logic                     neg;
  logic [VMAG_W-1:0]        vmag;

  // cosine magnitude table, Q.F unsigned
  logic [COS_W-1:0] cos_tab [COS_DEPTH];

  for (genvar g = 0; g < COS_DEPTH; g++) begin : g_cos
    if (g < COS_ENTRIES) begin : g_ent
      localparam longint unsigned ROUNDED =
        (64'(cos_q30(g)) + (64'd1 << (29 - F))) >> (30 - F);
      assign cos_tab[g] = COS_W'(ROUNDED);
    end else begin : g_pad
      assign cos_tab[g] = '0;
    end
  end

  assign status.is_set = (act == ACT_SET);

  // theta stage
  logic signed [THETA_W-1:0] ah_prod;
  logic signed [THETA_W:0]   theta_sum;
  assign ah_prod   = acoef * head;
  assign theta_sum = $signed({7'b0, loc[DEG_W-1:1]}) + (THETA_W+1)'(ah_prod)
                   + (THETA_W+1)'(THETA_OFS);

  // divide by 360 through reciprocal
  logic [THETA_W+DIV_MUL_W-1:0] quo_full;
  assign quo_full = (THETA_W+DIV_MUL_W)'(theta_ofs) * (THETA_W+DIV_MUL_W)'(DIV_MUL);

  logic signed [PROD_W-1:0] p1_c;
  logic signed [PROD_W-1:0] tt_c;
  assign p1_c = cgain * lin;
  assign tt_c = wcoef * turn;

  // remainder with one correction step
  logic [THETA_W-1:0] rem_c;
  logic [THETA_W-1:0] rem_fix;
  assign rem_c   = theta_ofs - THETA_W'(quo) * THETA_W'(DEG_FULL);
  assign rem_fix = rem_c - THETA_W'(DEG_FULL);

  logic signed [SUM_W-1:0] p2_c;
  assign p2_c = p1 * cos_s;

  // rounding half away from zero
  logic [SUM_W-1:0] mag_c;
  logic [SUM_W-1:0] rnd_c;
  assign mag_c = total[SUM_W-1] ? SUM_W'(-total) : SUM_W'(total);
  assign rnd_c = mag_c + (SUM_W'(1) << (F - 1));

  // sign, polarity, saturation, dead zone
  logic signed [VS_W-1:0]    vs_c;
  logic signed [SPEED_W-1:0] sat_c;
  logic signed [MAG_W-1:0]   s17_c;
  logic signed [MAG_W-1:0]   ms_c;
  logic signed [MAG_W-1:0]   dz_c;
  logic                      flip;

  assign flip = neg ^ dir[1];
  assign ms_c = $signed({{(MAG_W-DUTY_W){1'b0}}, mins});

  always_comb begin
    if (dir == 2'sd0) begin
      vs_c = '0;
    end else if (flip) begin
      vs_c = -$signed({1'b0, vmag});
    end else begin
      vs_c = $signed({1'b0, vmag});
    end
    if (vs_c > VS_W'(32767)) begin
      sat_c = 16'sh7fff;
    end else if (vs_c < -VS_W'(32768)) begin
      sat_c = 16'sh8000;
    end else begin
      sat_c = vs_c[SPEED_W-1:0];
    end
    s17_c = MAG_W'(sat_c);
    if (s17_c > 0 && s17_c < ms_c) begin
      dz_c = ms_c;
    end else if (s17_c < 0 && s17_c > -ms_c) begin
      dz_c = -ms_c;
    end else begin
      dz_c = s17_c;
    end
  end

  // bridge drive
  logic signed [SPEED_W-1:0] drv_s;
  logic signed [MAG_W-1:0]   drv_ext;
  logic [MAG_W-1:0]          drv_mag;
  logic [MAG_W-1:0]          drv_duty;
  logic                      drv_pos;

  always_comb begin
    drv_s    = (act == ACT_RUN_STORED) ? stored_speed : SPEED_W'(dspd);
    drv_ext  = MAG_W'(drv_s);
    drv_pos  = (drv_s > 0);
    drv_mag  = drv_pos ? MAG_W'(drv_ext) : MAG_W'(-drv_ext);
    drv_duty = (drv_mag < DUTY_CAP) ? drv_mag : DUTY_CAP;
  end

  // config and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      loc          <= '0;
      dir          <= 2'sd1;
      acoef        <= 4'sd1;
      wcoef        <= 7'sd1;
      cgain        <= 7'sd1;
      mins         <= '0;
      stored_speed <= '0;
      held_a       <= '0;
      held_b       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_LOCATION:     loc   <= cfg_data;
          REG_DIRECTION:    dir   <= cfg_data[1:0];
          REG_ANGLE_COEF:   acoef <= cfg_data[3:0];
          REG_ANGULAR_COEF: wcoef <= cfg_data[6:0];
          REG_COS_GAIN:     cgain <= cfg_data[6:0];
          REG_MIN_SPEED:    mins  <= cfg_data[DUTY_W-1:0];
          default: ;
        endcase
      end
      case (ctl.op)
        OP_FIN: stored_speed <= dz_c[SPEED_W-1:0];
        OP_DRIVE: begin
          if (act == ACT_BRAKE) begin
            held_a <= DUTY_CAP[DUTY_W-1:0];
            held_b <= DUTY_CAP[DUTY_W-1:0];
          end else if (drv_pos) begin
            held_a <= '0;
            held_b <= drv_duty[DUTY_W-1:0];
          end else begin
            held_a <= drv_duty[DUTY_W-1:0];
            held_b <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // item capture, arithmetic sequence and result register
  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      act  <= action_t'(action);
      lin  <= lin_speed;
      head <= heading_angle;
      turn <= turn_rate;
      dspd <= direct_speed;
    end
    case (ctl.op)
      OP_THETA: theta_ofs <= theta_sum[THETA_W-1:0];
      OP_DIV: begin
        quo <= quo_full[DIV_SHIFT +: QUO_W];
        p1  <= p1_c;
        tt  <= tt_c;
      end
      OP_FOLD: deg <= (rem_c >= THETA_W'(DEG_FULL)) ? rem_fix[DEG_W-1:0] : rem_c[DEG_W-1:0];
      OP_QUAD: begin
        if (deg <= DEG_W'(DEG_Q)) begin
          cos_idx <= deg[COS_IDX_W-1:0];
          cos_neg <= 1'b0;
        end else if (deg <= DEG_W'(DEG_HALF)) begin
          cos_idx <= COS_IDX_W'(DEG_W'(DEG_HALF) - deg);
          cos_neg <= 1'b1;
        end else if (deg <= DEG_W'(DEG_3Q)) begin
          cos_idx <= COS_IDX_W'(deg - DEG_W'(DEG_HALF));
          cos_neg <= 1'b1;
        end else begin
          cos_idx <= COS_IDX_W'(DEG_W'(DEG_FULL) - deg);
          cos_neg <= 1'b0;
        end
      end
      OP_ROM: cos_s <= cos_neg ? -$signed({1'b0, cos_tab[cos_idx]})
                               : $signed({1'b0, cos_tab[cos_idx]});
      OP_MUL: p2 <= p2_c;
      OP_SUM: total <= p2 + (SUM_W'(tt) <<< F);
      OP_RND: begin
        neg  <= total[SUM_W-1];
        vmag <= VMAG_W'(rnd_c >> F);
      end
      default: ;
    endcase
    if (ctl.load_out) begin
      pin_a_duty   <= held_a;
      pin_b_duty   <= held_b;
      pins_updated <= (act != ACT_SET);
      wheel_speed  <= stored_speed;
    end
  end

endmodule

### design/wsmhd_checker.sv
// wsmhd_checker: port-level assertions for the wheel drive block and its bind
`timescale 1ns / 1ps

module wsmhd_checker import wsmhd_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      cmd_valid,
  input logic                      cmd_ready,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic [DUTY_W-1:0]         pin_a,
  input logic [DUTY_W-1:0]         pin_b,
  input logic                      updated,
  input logic signed [SPEED_W-1:0] speed
);

  // one command at a time: no beat taken in the cycle after one was taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("command accepted while another is in flight");

  // only brake drives both bridge inputs, and then to the same duty
  a_both_high_brake: assert property (@(posedge clk) disable iff (rst)
    (res_valid && updated && pin_a != '0 && pin_b != '0) |-> (pin_a == pin_b))
    else $error("both bridge inputs driven with different duties");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result shown right after reset");

  // stalled result stays up and holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=>
      ($stable(pin_a) && $stable(pin_b) && $stable(updated) && $stable(speed)))
    else $error("result changed while stalled");

endmodule

bind wheel_speed_mixer_hbridge_drive wsmhd_checker u_wsmhd_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .pin_a     (res.pin_a_duty),
  .pin_b     (res.pin_b_duty),
  .updated   (res.pins_updated),
  .speed     (res.wheel_speed)
);
